// ===== sv/sde_pkg.sv =====
// Shared types, constants and tables of the SHA-256 digest engine.
// Depends on nothing; used by sde_ctrl, sde_datapath and sha256_digest_engine.
package sde_pkg;

    localparam int COUNT_W = 61;
    localparam int WORD_W  = 32;
    localparam int BLOCK_W = 512;

    // Source of the byte shifted into the block buffer.
    localparam logic [1:0] SRC_MSG  = 2'd0;
    localparam logic [1:0] SRC_MARK = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;
    localparam logic [1:0] SRC_LEN  = 2'd3;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_FILL   = 6'd56;
    localparam logic [5:0] LAST_FILL  = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    typedef struct packed {
        logic       shift;
        logic [1:0] byte_src;
        logic       count_inc;
        logic [2:0] sub_idx;
        logic [5:0] rnd;
        logic       start;
        logic       round;
        logic       add;
        logic       reinit;
    } sde_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
    } sde_status_t;

    function automatic logic [WORD_W-1:0] initial_h(input logic [2:0] idx);
        logic [WORD_W-1:0] h;
        case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [5:0] idx);
        logic [WORD_W-1:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

// ===== sv/sha256_digest_engine.sv =====
// SHA-256 digest engine: a byte item is shifted in while idle; the byte that fills a block
// starts a compression (64 rounds on one shared round unit, then the chaining add).
// An end item shifts the padding in at one byte a cycle, held while a compression runs,
// up to 56, then 8 length bytes, with one or two compressions, then offers eight digest
// beats, one per accepted beat. Input is accepted only in the idle state, not during a compression.
// Reset loads the initial hash values and clears the byte count; buffer data is undefined.
module sha256_digest_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_msg_byte,
    input  logic                          s_has_byte,
    input  logic                          s_message_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sde_pkg::WORD_W-1:0]    m_digest_word,
    output logic [2:0]                    m_word_index,
    output logic                          m_digest_last
);

    sde_pkg::sde_cmd_t    cmd;
    sde_pkg::sde_status_t status;

    sde_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_has_byte    (s_has_byte),
        .s_message_end (s_message_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_word_index  (m_word_index),
        .m_digest_last (m_digest_last),
        .status        (status),
        .cmd           (cmd)
    );

    sde_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_msg_byte    (s_msg_byte),
        .cmd           (cmd),
        .status        (status),
        .m_digest_word (m_digest_word)
    );

endmodule

// ===== sv/sde_datapath.sv =====
// Datapath of the SHA-256 digest engine: block buffer and message schedule,
// round logic, chaining words and byte count. Depends on sde_pkg.
module sde_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [7:0]                    s_msg_byte,
    input  sde_pkg::sde_cmd_t             cmd,
    output sde_pkg::sde_status_t          status,
    output logic [sde_pkg::WORD_W-1:0]    m_digest_word
);

    localparam int WW = sde_pkg::WORD_W;
    localparam int BW = sde_pkg::BLOCK_W;

    function automatic logic [WW-1:0] rotr(input logic [WW-1:0] x, input int n);
        return (x >> n) | (x << (WW - n));
    endfunction

    // The buffer doubles as the 16-word schedule window; word 0 sits at the top.
    function automatic logic [WW-1:0] word_at(input logic [BW-1:0] blk, input int idx);
        return blk[BW-1-WW*idx -: WW];
    endfunction

    logic [BW-1:0]                 msg_reg,   msg_next;
    logic [WW-1:0]                 var_reg   [8];
    logic [WW-1:0]                 var_next  [8];
    logic [WW-1:0]                 chain_reg [8];
    logic [WW-1:0]                 chain_next[8];
    logic [sde_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [5:0]                    fill_reg,  fill_next;

    logic [63:0]   len_bits;
    logic [7:0]    byte_in;
    logic [WW-1:0] w0, w1, w9, w14, w_new;
    logic [WW-1:0] s0, s1, big_s0, big_s1, ch, maj, t1, t2;

    assign len_bits = {count_reg, 3'b000};

    always_comb begin
        case (cmd.byte_src)
            sde_pkg::SRC_MSG:  byte_in = s_msg_byte;
            sde_pkg::SRC_MARK: byte_in = sde_pkg::PAD_MARKER;
            sde_pkg::SRC_ZERO: byte_in = 8'h00;
            sde_pkg::SRC_LEN:  byte_in = len_bits[{~cmd.sub_idx, 3'b000} +: 8];
            default:           byte_in = 8'h00;
        endcase
    end

    assign w0    = word_at(msg_reg, 0);
    assign w1    = word_at(msg_reg, 1);
    assign w9    = word_at(msg_reg, 9);
    assign w14   = word_at(msg_reg, 14);
    assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    assign w_new = w0 + s0 + w9 + s1;

    assign big_s1 = rotr(var_reg[4], 6) ^ rotr(var_reg[4], 11) ^ rotr(var_reg[4], 25);
    assign big_s0 = rotr(var_reg[0], 2) ^ rotr(var_reg[0], 13) ^ rotr(var_reg[0], 22);
    assign ch     = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
    assign maj    = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                  ^ (var_reg[1] & var_reg[2]);
    assign t1     = var_reg[7] + big_s1 + ch + sde_pkg::round_k(cmd.rnd) + w0;
    assign t2     = big_s0 + maj;

    always_comb begin
        msg_next = msg_reg;
        if (cmd.shift) begin
            msg_next = {msg_reg[BW-9:0], byte_in};
        end else if (cmd.round) begin
            msg_next = {msg_reg[BW-WW-1:0], w_new};
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            var_next[i]   = var_reg[i];
            chain_next[i] = chain_reg[i];
        end
        if (cmd.start) begin
            for (int i = 0; i < 8; i++) begin
                var_next[i] = chain_reg[i];
            end
        end else if (cmd.round) begin
            var_next[7] = var_reg[6];
            var_next[6] = var_reg[5];
            var_next[5] = var_reg[4];
            var_next[4] = var_reg[3] + t1;
            var_next[3] = var_reg[2];
            var_next[2] = var_reg[1];
            var_next[1] = var_reg[0];
            var_next[0] = t1 + t2;
        end
        if (cmd.reinit) begin
            for (int i = 0; i < 8; i++) begin
                chain_next[i] = sde_pkg::initial_h(3'(i));
            end
        end else if (cmd.add) begin
            for (int i = 0; i < 8; i++) begin
                chain_next[i] = chain_reg[i] + var_reg[i];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        fill_next  = fill_reg;
        if (cmd.reinit) begin
            count_next = '0;
        end else if (cmd.count_inc) begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.shift) begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        msg_reg <= msg_next;
        for (int i = 0; i < 8; i++) begin
            var_reg[i] <= var_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= sde_pkg::initial_h(3'(i));
            end
            count_reg <= '0;
            fill_reg  <= '0;
        end else begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= chain_next[i];
            end
            count_reg <= count_next;
            fill_reg  <= fill_next;
        end
    end

    assign status.fill   = fill_reg;
    assign m_digest_word = chain_reg[cmd.sub_idx];

endmodule

// ===== sv/sde_ctrl.sv =====
// Controller of the SHA-256 digest engine: handshakes, padding sequence,
// round counting and digest word output. Depends on sde_pkg.
module sde_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_has_byte,
    input  logic                  s_message_end,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_word_index,
    output logic                  m_digest_last,
    input  sde_pkg::sde_status_t  status,
    output sde_pkg::sde_cmd_t     cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_ZERO  = 3'd4;
    localparam logic [2:0] S_LEN   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] ret_reg,   ret_next;
    logic [5:0] rnd_reg,   rnd_next;
    logic [2:0] sub_reg,   sub_next;
    logic       block_full;

    assign block_full = (status.fill == sde_pkg::LAST_FILL);

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        rnd_next   = rnd_reg;
        sub_next   = sub_reg;

        cmd           = '0;
        cmd.byte_src  = sde_pkg::SRC_MSG;
        cmd.rnd       = rnd_reg;
        cmd.sub_idx   = sub_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_has_byte) begin
                        cmd.shift     = 1'b1;
                        cmd.count_inc = 1'b1;
                    end
                    // The byte that fills the buffer starts a compression; an end
                    // flag on the same beat resumes with padding afterward.
                    if (s_has_byte && block_full) begin
                        cmd.start  = 1'b1;
                        rnd_next   = '0;
                        state_next = S_ROUND;
                        ret_next   = s_message_end ? S_MARK : S_IDLE;
                    end else if (s_message_end) begin
                        state_next = S_MARK;
                    end
                end
            end
            S_ROUND: begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 1'b1;
                if (rnd_reg == sde_pkg::LAST_ROUND) begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                cmd.add    = 1'b1;
                state_next = ret_reg;
            end
            S_MARK: begin
                cmd.shift    = 1'b1;
                cmd.byte_src = sde_pkg::SRC_MARK;
                if (block_full) begin
                    cmd.start  = 1'b1;
                    rnd_next   = '0;
                    state_next = S_ROUND;
                    ret_next   = S_ZERO;
                end else begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO: begin
                if (status.fill == sde_pkg::LEN_FILL) begin
                    sub_next   = '0;
                    state_next = S_LEN;
                end else begin
                    cmd.shift    = 1'b1;
                    cmd.byte_src = sde_pkg::SRC_ZERO;
                    if (block_full) begin
                        cmd.start  = 1'b1;
                        rnd_next   = '0;
                        state_next = S_ROUND;
                        ret_next   = S_ZERO;
                    end
                end
            end
            S_LEN: begin
                cmd.shift    = 1'b1;
                cmd.byte_src = sde_pkg::SRC_LEN;
                sub_next     = sub_reg + 1'b1;
                if (sub_reg == sde_pkg::LAST_WORD) begin
                    cmd.start  = 1'b1;
                    rnd_next   = '0;
                    state_next = S_ROUND;
                    ret_next   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (m_ready) begin
                    sub_next = sub_reg + 1'b1;
                    if (sub_reg == sde_pkg::LAST_WORD) begin
                        cmd.reinit = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            rnd_reg   <= '0;
            sub_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            rnd_reg   <= rnd_next;
            sub_reg   <= sub_next;
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = (state_reg == S_EMIT);
    assign m_word_index  = sub_reg;
    assign m_digest_last = (sub_reg == sde_pkg::LAST_WORD);

endmodule
